// ===== rtl/core/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
// No dependencies; imported by the writer top level and the port checker.
package tccw_pkg;

    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = 16;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int OCOL_W   = 7;
    localparam int OROW_W   = 5;
    localparam int SHOWN_W  = 11;

    localparam int S_TDATA_W = 32;   // char, attr, read_row, read_col padded to bytes
    localparam int M_TDATA_W = 40;   // cell, col, row, shown padded to bytes

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ATTR_W-1:0] t_attr;
    typedef logic [CELL_W-1:0] t_cell;

    localparam t_char CH_NEWLINE   = 8'h0A;
    localparam t_char CH_RETURN    = 8'h0D;
    localparam t_char CH_BACKSPACE = 8'h08;
    localparam t_char BLANK_CHAR   = 8'h20;
    localparam t_attr RESET_ATTR   = 8'h0F;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

endpackage

// ===== rtl/core/text_console_character_writer.sv =====
// Channel  Dir  Word (tdata)                                    Side band
// s_axis   in   char_code, attribute, read_row, read_col        tuser action, tlast end_of_write
// m_axis   out  cell_data, cursor_col, cursor_row, shown pos    none
//
// A put without scroll or a read writes or addresses the cell memory in the idle state,
// then forms the result word from the updated cursor or the read data in the done state.
// A put that scrolls adds a row copy of (ROWS-1)*COLUMNS cells (read then write per
// cell through the one memory port pair) and a blank fill of the last row's COLUMNS cells.
// After reset, a clearing pass writes all ROWS*COLUMNS cells before input is taken.
// Input is taken only when the sequencer is idle and the result register is free.
module text_console_character_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [tccw_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [7:0] char_code, [15:8] attribute,
                                                           // [20:16] read_row, [27:21] read_col
    input  logic        s_axis_tuser,   // [0] action
    input  logic        s_axis_tlast,   // end_of_write
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [tccw_pkg::M_TDATA_W-1:0] m_axis_tdata   // [15:0] cell_data, [22:16] cursor_col,
                                                          // [27:23] cursor_row,
                                                          // [38:28] shown_cursor_pos
);
    import tccw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int COPY  = (ROWS - 1) * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int RW1   = RW + 1;
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_FILL,
        ST_DONE
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_idx;
    logic [RW-1:0]   r_row;
    logic [CW-1:0]   r_col;
    logic [SHOWN_W-1:0] r_shown;
    t_attr           r_attr;
    logic            r_last;
    logic            r_is_read;
    logic            r_zero;
    logic            r_ovalid;
    t_cell           r_o_cell;
    logic [OCOL_W-1:0]  r_o_col;
    logic [OROW_W-1:0]  r_o_row;
    logic [SHOWN_W-1:0] r_o_shown;

    // input fields
    t_char               in_char;
    t_attr               in_attr;
    logic [RROW_W-1:0]   in_rrow;
    logic [RCOL_W-1:0]   in_rcol;
    logic                in_accept;
    logic                in_range;

    // put cursor update
    logic [RW1-1:0]  n_row_wide;
    logic [CW-1:0]   n_col;
    logic            put_print;
    logic            put_scroll;

    // memory and address unit
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_cell           mem_wdata;
    logic [AW-1:0]   mem_raddr;
    t_cell           mem_rdata;
    logic [RW-1:0]   au_row;
    logic [CW-1:0]   au_col;
    logic [AW-1:0]   au_addr;

    assign in_char = s_axis_tdata[7:0];
    assign in_attr = s_axis_tdata[15:8];
    assign in_rrow = s_axis_tdata[20:16];
    assign in_rcol = s_axis_tdata[27:21];

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_range      = (32'(in_rrow) < ROWS) && (32'(in_rcol) < COLUMNS);

    // address unit: read address while a read is offered, cursor otherwise
    always_comb begin
        if (r_state == ST_IDLE && s_axis_tuser == ACT_READ) begin
            au_row = RW'(in_rrow);
            au_col = CW'(in_rcol);
        end else begin
            au_row = r_row;
            au_col = r_col;
        end
    end

    tccw_addr #(
        .COLUMNS(COLUMNS),
        .RW     (RW),
        .CW     (CW),
        .AW     (AW)
    ) u_addr (
        .i_row (au_row),
        .i_col (au_col),
        .o_addr(au_addr)
    );

    // next cursor for a put
    always_comb begin
        n_row_wide = {1'b0, r_row};
        n_col      = r_col;
        put_print  = 1'b0;
        case (in_char)
            CH_NEWLINE: begin
                n_row_wide = {1'b0, r_row} + RW1'(1);
                n_col      = '0;
            end
            CH_RETURN: begin
                n_col = '0;
            end
            CH_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col = r_col - CW'(1);
                end
            end
            default: begin
                put_print = 1'b1;
                if (r_col == CW'(COLUMNS - 1)) begin
                    n_col      = '0;
                    n_row_wide = {1'b0, r_row} + RW1'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        endcase
        put_scroll = (n_row_wide == RW1'(ROWS));
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        mem_raddr = au_addr;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
            end
            ST_IDLE: begin
                mem_we    = in_accept && s_axis_tuser == ACT_PUT && put_print;
                mem_waddr = au_addr;
                mem_wdata = {in_attr, in_char};
            end
            ST_SCR_RD: begin
                mem_raddr = r_idx + AW'(COLUMNS);
            end
            ST_SCR_WR: begin
                mem_we = 1'b1;
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = {r_attr, BLANK_CHAR};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    tccw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_shown   <= '0;
            r_ovalid  <= 1'b0;
            r_last    <= 1'b0;
            r_is_read <= 1'b0;
            r_zero    <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (r_idx == AW'(CELLS - 1)) begin
                        r_idx   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_attr <= in_attr;
                        r_last <= s_axis_tlast;
                        r_zero <= !in_range;
                        r_idx  <= '0;
                        if (s_axis_tuser == ACT_READ) begin
                            r_is_read <= 1'b1;
                            r_state   <= ST_DONE;
                        end else begin
                            r_is_read <= 1'b0;
                            r_col     <= n_col;
                            if (put_scroll) begin
                                r_row   <= RW'(ROWS - 1);
                                r_state <= ST_SCR_RD;
                            end else begin
                                r_row   <= RW'(n_row_wide);
                                r_state <= ST_DONE;
                            end
                        end
                    end
                end
                ST_SCR_RD: begin
                    r_state <= ST_SCR_WR;
                end
                ST_SCR_WR: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == AW'(COPY - 1)) begin
                        r_state <= ST_FILL;
                    end else begin
                        r_state <= ST_SCR_RD;
                    end
                end
                ST_FILL: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == AW'(CELLS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // result slot was free at accept, so load it now
                    r_ovalid <= 1'b1;
                    r_o_col  <= OCOL_W'(r_col);
                    r_o_row  <= OROW_W'(r_row);
                    if (r_is_read) begin
                        r_o_cell  <= r_zero ? '0 : mem_rdata;
                        r_o_shown <= r_shown;
                    end else begin
                        r_o_cell <= '0;
                        if (r_last) begin
                            r_shown   <= SHOWN_W'(au_addr);
                            r_o_shown <= SHOWN_W'(au_addr);
                        end else begin
                            r_o_shown <= r_shown;
                        end
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_o_shown, r_o_row, r_o_col, r_o_cell};

endmodule

// ===== rtl/core/tccw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tccw_addr.sv =====
// Shared cell address unit: row * COLUMNS + col.
// Depends on nothing but its parameters; used for cursor writes, reads and shown position.
module tccw_addr #(
    parameter int COLUMNS = 80,
    parameter int RW      = 5,
    parameter int CW      = 7,
    parameter int AW      = 11
) (
    input  logic [RW-1:0] i_row,
    input  logic [CW-1:0] i_col,
    output logic [AW-1:0] o_addr
);

    // row is below ROWS whenever the result is used, so AW bits hold it
    assign o_addr = AW'(i_row) * AW'(COLUMNS) + AW'(i_col);

endmodule

// ===== rtl/core/tccw_port_checker.sv =====
// Port-level checks for the text console character writer.
// Depends on tccw_pkg; bound to the top level at the end of this file.
module tccw_port_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [tccw_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import tccw_pkg::*;

    logic s_acc;
    logic [OCOL_W-1:0] out_col;
    logic [OROW_W-1:0] out_row;

    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign out_col = m_axis_tdata[22:16];
    assign out_row = m_axis_tdata[27:23];

    // a result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped or changed while stalled");

    // one word in flight: no new input in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("input taken while previous word still in work");

    // an accepted word finds the result slot free
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !m_axis_tvalid)
        else $error("result slot busy after accept");

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(out_col) < COLUMNS) && (32'(out_row) < ROWS || ROWS > 32))
        else $error("cursor off screen");

endmodule

bind text_console_character_writer tccw_port_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_port_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
